/* src/bptc_pkg.sv */
package bptc_pkg;

    localparam int RawW   = 24;
    localparam int CoefW  = 16;
    localparam int TempW  = 20;
    localparam int PresW  = 32;
    localparam int IdxW   = 3;

    typedef enum logic [IdxW-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

    localparam logic [CoefW-1:0] C1_RESET = 16'd40127;
    localparam logic [CoefW-1:0] C2_RESET = 16'd36924;
    localparam logic [CoefW-1:0] C3_RESET = 16'd23317;
    localparam logic [CoefW-1:0] C4_RESET = 16'd23282;
    localparam logic [CoefW-1:0] C5_RESET = 16'd33464;
    localparam logic [CoefW-1:0] C6_RESET = 16'd28312;

    // temperature offset from 20.00 degC and the -15.00 degC break point
    localparam logic signed [20:0] TEMP_BASE = 21'sd2000;
    localparam logic signed [17:0] A_DEEP    = -18'sd3500;
    localparam logic signed [18:0] B_OFS     = 19'sd3500;

    localparam logic signed [TempW-1:0] TEMP_MIN = -20'sd270000;
    localparam logic signed [TempW-1:0] TEMP_MAX = 20'sd140000;
    localparam logic signed [PresW-1:0] PRES_MAX = 32'sh7fff_ffff;
    localparam logic signed [PresW-1:0] PRES_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [CoefW-1:0] c1;
        logic [CoefW-1:0] c2;
        logic [CoefW-1:0] c3;
        logic [CoefW-1:0] c4;
        logic [CoefW-1:0] c5;
        logic [CoefW-1:0] c6;
    } t_coeffs;

    typedef struct packed {
        logic [RawW-1:0]    d1;
        logic signed [17:0] a;
        logic [16:0]        t2;
        logic signed [35:0] off;
        logic signed [35:0] sens;
    } t_front;

endpackage

/* src/bptc_if.sv */
interface bptc_in_if;
    logic                           valid;
    logic                           ready;
    logic [bptc_pkg::RawW-1:0]      d1_raw;
    logic [bptc_pkg::RawW-1:0]      d2_raw;
    modport source (output valid, output d1_raw, output d2_raw, input ready);
    modport sink (input valid, input d1_raw, input d2_raw, output ready);
endinterface

interface bptc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bptc_pkg::TempW-1:0] temperature_centi;
    logic signed [bptc_pkg::PresW-1:0] pressure_centi;
    modport source (output valid, output temperature_centi, output pressure_centi,
                    input ready);
    modport sink (input valid, input temperature_centi, input pressure_centi,
                  output ready);
endinterface

interface bptc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bptc_pkg::IdxW-1:0]      reg_index;
    logic [bptc_pkg::CoefW-1:0]     wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* src/bptc_cfg_regs.sv */
module bptc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bptc_cfg_if.sink          i_cfg,
    output bptc_pkg::t_coeffs o_coeffs
);

    bptc_pkg::t_coeffs r_coeffs;

    assign i_cfg.ready = 1'b1;
    assign o_coeffs    = r_coeffs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs.c1 <= bptc_pkg::C1_RESET;
            r_coeffs.c2 <= bptc_pkg::C2_RESET;
            r_coeffs.c3 <= bptc_pkg::C3_RESET;
            r_coeffs.c4 <= bptc_pkg::C4_RESET;
            r_coeffs.c5 <= bptc_pkg::C5_RESET;
            r_coeffs.c6 <= bptc_pkg::C6_RESET;
        end else if (i_cfg.valid) begin
            case (bptc_pkg::t_reg_idx'(i_cfg.reg_index))
                bptc_pkg::REG_C1: r_coeffs.c1 <= i_cfg.wr_data;
                bptc_pkg::REG_C2: r_coeffs.c2 <= i_cfg.wr_data;
                bptc_pkg::REG_C3: r_coeffs.c3 <= i_cfg.wr_data;
                bptc_pkg::REG_C4: r_coeffs.c4 <= i_cfg.wr_data;
                bptc_pkg::REG_C5: r_coeffs.c5 <= i_cfg.wr_data;
                bptc_pkg::REG_C6: r_coeffs.c6 <= i_cfg.wr_data;
                default: r_coeffs <= r_coeffs;
            endcase
        end
    end

endmodule

/* src/bptc_front.sv */
module bptc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bptc_pkg::t_coeffs             i_coeffs,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bptc_pkg::RawW-1:0]     i_d1,
    input  logic [bptc_pkg::RawW-1:0]     i_d2,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bptc_pkg::t_front              o_front
);

    logic [2:0] r_vld;
    logic [2:0] w_en;

    // stage 1: dT
    logic signed [24:0]          r_dt1;
    logic [bptc_pkg::RawW-1:0]   r_d1_1;
    logic signed [24:0]          n_dt1;

    // stage 2: products with dT
    logic signed [40:0]          r_p6_2;
    logic signed [40:0]          r_p4_2;
    logic signed [40:0]          r_p3_2;
    logic signed [48:0]          r_pdd2;
    logic [bptc_pkg::RawW-1:0]   r_d1_2;
    logic signed [40:0]          n_p6_2;
    logic signed [40:0]          n_p4_2;
    logic signed [40:0]          n_p3_2;
    logic signed [48:0]          n_pdd2;

    // stage 3: first order terms
    logic signed [17:0]          r_a3;
    logic [16:0]                 r_t2_3;
    logic signed [35:0]          r_off3;
    logic signed [35:0]          r_sens3;
    logic [bptc_pkg::RawW-1:0]   r_d1_3;
    logic signed [35:0]          n_off3;
    logic signed [35:0]          n_sens3;

    always_comb begin
        w_en[2] = !r_vld[2] || i_ready;
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_en[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_comb begin
        n_dt1   = $signed({1'b0, i_d2}) - $signed({1'b0, i_coeffs.c5, 8'b0});
        n_p6_2  = 41'(r_dt1) * 41'($signed({1'b0, i_coeffs.c6}));
        n_p4_2  = 41'(r_dt1) * 41'($signed({1'b0, i_coeffs.c4}));
        n_p3_2  = 41'(r_dt1) * 41'($signed({1'b0, i_coeffs.c3}));
        n_pdd2  = 49'(r_dt1) * 49'(r_dt1);
        n_off3  = 36'($signed({2'b0, i_coeffs.c2, 16'b0})) + 36'($signed(r_p4_2[40:7]));
        n_sens3 = 36'($signed({2'b0, i_coeffs.c1, 15'b0})) + 36'($signed(r_p3_2[40:8]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dt1  <= n_dt1;
            r_d1_1 <= i_d1;
        end
        if (w_en[1]) begin
            r_p6_2 <= n_p6_2;
            r_p4_2 <= n_p4_2;
            r_p3_2 <= n_p3_2;
            r_pdd2 <= n_pdd2;
            r_d1_2 <= r_d1_1;
        end
        if (w_en[2]) begin
            r_a3    <= $signed(r_p6_2[40:23]);
            r_t2_3  <= r_pdd2[47:31];
            r_off3  <= n_off3;
            r_sens3 <= n_sens3;
            r_d1_3  <= r_d1_2;
        end
    end

    always_comb begin
        o_front.d1   = r_d1_3;
        o_front.a    = r_a3;
        o_front.t2   = r_t2_3;
        o_front.off  = r_off3;
        o_front.sens = r_sens3;
    end

endmodule

/* src/bptc_back.sv */
module bptc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  bptc_pkg::t_front                   i_front,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [bptc_pkg::TempW-1:0]  o_temperature_centi,
    output logic signed [bptc_pkg::PresW-1:0]  o_pressure_centi
);

    logic [6:0] r_vld;
    logic [6:0] w_en;

    // stage 4: squares, final temperature
    logic signed [bptc_pkg::TempW-1:0] r_temp4;
    logic [34:0]                       r_aa4;
    logic [35:0]                       r_bb4;
    logic                              r_lt2000_4;
    logic                              r_lt1500_4;
    logic signed [35:0]                r_off4;
    logic signed [35:0]                r_sens4;
    logic [bptc_pkg::RawW-1:0]         r_d1_4;
    logic signed [20:0]                n_temp4;
    logic signed [18:0]                n_b4;
    logic signed [35:0]                n_aa4;
    logic signed [37:0]                n_bb4;
    logic                              n_lt2000_4;

    // stage 5: second order terms
    logic signed [bptc_pkg::TempW-1:0] r_temp5;
    logic [39:0]                       r_off2_5;
    logic [39:0]                       r_sens2_5;
    logic signed [35:0]                r_off5;
    logic signed [35:0]                r_sens5;
    logic [bptc_pkg::RawW-1:0]         r_d1_5;
    logic [37:0]                       n_aa5;
    logic [38:0]                       n_bb7;
    logic [39:0]                       n_bb11;
    logic [39:0]                       n_off2_5;
    logic [39:0]                       n_sens2_5;

    // stage 6: corrected offset and sensitivity
    logic signed [bptc_pkg::TempW-1:0] r_temp6;
    logic signed [41:0]                r_offf6;
    logic signed [41:0]                r_sensf6;
    logic [bptc_pkg::RawW-1:0]         r_d1_6;

    // stage 7: partial products of D1 * SENS
    logic signed [bptc_pkg::TempW-1:0] r_temp7;
    logic [44:0]                       r_lo7;
    logic signed [45:0]                r_hi7;
    logic signed [41:0]                r_offf7;

    // stage 8: (D1 * SENS) >> 21
    logic signed [bptc_pkg::TempW-1:0] r_temp8;
    logic signed [46:0]                r_x8;
    logic signed [41:0]                r_offf8;

    // stage 9: minus offset
    logic signed [bptc_pkg::TempW-1:0] r_temp9;
    logic signed [47:0]                r_y9;

    // stage 10: output register
    logic signed [bptc_pkg::TempW-1:0] r_temp10;
    logic signed [bptc_pkg::PresW-1:0] r_pres10;
    logic signed [32:0]                n_p10;
    logic signed [bptc_pkg::PresW-1:0] n_pres10;

    always_comb begin
        w_en[6] = !r_vld[6] || i_ready;
        for (int k = 5; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[6];
    assign o_temperature_centi = r_temp10;
    assign o_pressure_centi    = r_pres10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_lt2000_4 = i_front.a[17];
        n_temp4    = bptc_pkg::TEMP_BASE + 21'(i_front.a)
                   - (n_lt2000_4 ? $signed({4'b0, i_front.t2}) : 21'sd0);
        n_b4       = 19'(i_front.a) + bptc_pkg::B_OFS;
        n_aa4      = 36'(i_front.a) * 36'(i_front.a);
        n_bb4      = 38'(n_b4) * 38'(n_b4);

        n_aa5  = {3'b0, r_aa4} + {1'b0, r_aa4, 2'b0};
        n_bb7  = {r_bb4, 3'b0} - {3'b0, r_bb4};
        n_bb11 = {1'b0, r_bb4, 3'b0} + {3'b0, r_bb4, 1'b0} + {4'b0, r_bb4};
        if (r_lt2000_4) begin
            n_off2_5  = {3'b0, n_aa5[37:1]} + (r_lt1500_4 ? {1'b0, n_bb7} : 40'd0);
            n_sens2_5 = {4'b0, n_aa5[37:2]} + (r_lt1500_4 ? {1'b0, n_bb11[39:1]} : 40'd0);
        end else begin
            n_off2_5  = '0;
            n_sens2_5 = '0;
        end

        n_p10 = $signed(r_y9[47:15]);
        if (n_p10[32] != n_p10[31]) begin
            n_pres10 = n_p10[32] ? bptc_pkg::PRES_MIN : bptc_pkg::PRES_MAX;
        end else begin
            n_pres10 = $signed(n_p10[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_temp4    <= n_temp4[bptc_pkg::TempW-1:0];
            r_aa4      <= n_aa4[34:0];
            r_bb4      <= n_bb4[35:0];
            r_lt2000_4 <= n_lt2000_4;
            r_lt1500_4 <= (i_front.a < bptc_pkg::A_DEEP);
            r_off4     <= i_front.off;
            r_sens4    <= i_front.sens;
            r_d1_4     <= i_front.d1;
        end
        if (w_en[1]) begin
            r_temp5   <= r_temp4;
            r_off2_5  <= n_off2_5;
            r_sens2_5 <= n_sens2_5;
            r_off5    <= r_off4;
            r_sens5   <= r_sens4;
            r_d1_5    <= r_d1_4;
        end
        if (w_en[2]) begin
            r_temp6  <= r_temp5;
            r_offf6  <= 42'(r_off5) - $signed({2'b0, r_off2_5});
            r_sensf6 <= 42'(r_sens5) - $signed({2'b0, r_sens2_5});
            r_d1_6   <= r_d1_5;
        end
        if (w_en[3]) begin
            r_temp7 <= r_temp6;
            r_lo7   <= 45'(r_d1_6) * 45'(r_sensf6[20:0]);
            r_hi7   <= 46'($signed({1'b0, r_d1_6})) * 46'($signed(r_sensf6[41:21]));
            r_offf7 <= r_offf6;
        end
        if (w_en[4]) begin
            r_temp8 <= r_temp7;
            r_x8    <= 47'(r_hi7) + 47'($signed({1'b0, r_lo7[44:21]}));
            r_offf8 <= r_offf7;
        end
        if (w_en[5]) begin
            r_temp9 <= r_temp8;
            r_y9    <= 48'(r_x8) - 48'(r_offf8);
        end
        if (w_en[6]) begin
            r_temp10 <= r_temp9;
            r_pres10 <= n_pres10;
        end
    end

`ifndef ASSERT_OFF
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline valid bits not cleared by reset");

    a_deep_implies_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && r_lt1500_4 |-> r_lt2000_4)
        else $error("low temperature term without second order correction");

    a_warm_no_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en[1] && r_vld[0] && !r_lt2000_4 |=> r_off2_5 == '0 && r_sens2_5 == '0)
        else $error("second order correction applied above 20 degC");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_temperature_centi >= bptc_pkg::TEMP_MIN
                 && o_temperature_centi <= bptc_pkg::TEMP_MAX)
        else $error("temperature out of range");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && !w_en[5] |=> r_vld[5] && $stable(r_y9))
        else $error("stalled item lost in pipeline");
`endif

endmodule

/* src/baro_pressure_temp_compensation_unit.sv */
// channel   dir   handshake      payload
// i_in      in    valid/ready    d1_raw[23:0], d2_raw[23:0]
// o_out     out   valid/ready    temperature_centi[19:0] s, pressure_centi[31:0] s
// i_cfg     in    valid/ready    reg_index[2:0], wr_data[15:0]
//
// one pair per cycle sustained while o_out is ready; a pair passes from input transfer
// to result valid through the ten register stages of the arithmetic pipeline
// synchronous active-low reset clears valid bits and loads coefficient defaults
// a stalled output holds its result; bubbles inside the pipe still fill behind it
// config is always ready; writes to index 6 or 7 are dropped
module baro_pressure_temp_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bptc_in_if.sink     i_in,
    bptc_out_if.source  o_out,
    bptc_cfg_if.sink    i_cfg
);

    bptc_pkg::t_coeffs w_coeffs;
    bptc_pkg::t_front  w_front;
    logic              w_front_valid;
    logic              w_back_ready;

    bptc_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_coeffs (w_coeffs)
    );

    bptc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coeffs (w_coeffs),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_d1     (i_in.d1_raw),
        .i_d2     (i_in.d2_raw),
        .o_valid  (w_front_valid),
        .i_ready  (w_back_ready),
        .o_front  (w_front)
    );

    bptc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (w_front_valid),
        .o_ready             (w_back_ready),
        .i_front             (w_front),
        .o_valid             (o_out.valid),
        .i_ready             (o_out.ready),
        .o_temperature_centi (o_out.temperature_centi),
        .o_pressure_centi    (o_out.pressure_centi)
    );

endmodule
